// ===== hdl/hll_pkg.sv =====
// shared types, constants and helpers of the hyperloglog sketch
package hll_pkg;

	localparam int MAX_PRECISION = 16;
	localparam int MIN_PRECISION = 4;
	localparam int IDX_W         = MAX_PRECISION;
	localparam int DEPTH         = 1 << MAX_PRECISION;
	localparam int RANK_W        = 6;
	localparam int FRAC_BITS     = 47;
	localparam int PREC_W        = 5;
	localparam int ZCNT_W        = MAX_PRECISION + 1;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(14);

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_SUM   = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	localparam logic [63:0] HASH_C0 = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] HASH_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HASH_C2 = 64'h94d049bb133111eb;
	localparam int HASH_S1 = 30;
	localparam int HASH_S2 = 27;
	localparam int HASH_S3 = 31;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] value;
	} item_t;

	typedef struct packed {
		logic [63:0]       inv_rank_sum;
		logic [ZCNT_W-1:0] zero_count;
	} result_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  idx;
		logic [RANK_W-1:0] rank;
	} op_t;

	function automatic logic [PREC_W-1:0] eff_prec(input logic [PREC_W-1:0] p);
		logic [PREC_W-1:0] r;
		r = p;
		if (p < PREC_W'(MIN_PRECISION)) r = PREC_W'(MIN_PRECISION);
		if (p > PREC_W'(MAX_PRECISION)) r = PREC_W'(MAX_PRECISION);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] last_index(input logic [PREC_W-1:0] p);
		logic [IDX_W:0] n;
		n = (IDX_W+1)'(1) << p;
		return IDX_W'(n - (IDX_W+1)'(1));
	endfunction

endpackage

// ===== hdl/hll_front.sv =====
// front end: item intake, pipelined splitmix64 hash, index and rank extraction
module hll_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  hll_pkg::item_t            item,
	input  logic                      hold,
	input  logic [hll_pkg::PREC_W-1:0] prec,
	output logic                      push,
	output hll_pkg::op_t              push_op,
	input  logic                      q_full
);
	import hll_pkg::*;

	function automatic logic [2:0] clz8(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) n = 3'(7 - i);
		end
		return n;
	endfunction

	logic        adv;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [1:0]  kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic [63:0] y_s1, y_s3, h_s5;
	logic [63:0] ll_s2, ll_s4;
	logic [31:0] lh_s2, hl_s2, lh_s4, hl_s4;
	logic [IDX_W-1:0] idx_s6;
	logic [7:0]  nz_s6;
	logic [2:0]  lz_s6 [8];

	logic [63:0] sum0, mix1, z3, mix3, z5, mix5, m5;
	logic [6:0]  clz;

	assign adv        = !(valid_s6 && q_full);
	assign item_ready = adv && !hold;

	always_comb begin
		sum0 = item.value + HASH_C0;
		mix1 = sum0 ^ (sum0 >> HASH_S1);
		z3   = ll_s2 + {32'(lh_s2 + hl_s2), 32'd0};
		mix3 = z3 ^ (z3 >> HASH_S2);
		z5   = ll_s4 + {32'(lh_s4 + hl_s4), 32'd0};
		mix5 = z5 ^ (z5 >> HASH_S3);
		m5   = h_s5 & (~64'd0 >> prec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid && !hold && (item.kind != KIND_NONE);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= item.kind;
			y_s1    <= mix1;
			kind_s2 <= kind_s1;
			ll_s2   <= y_s1[31:0] * HASH_C1[31:0];
			lh_s2   <= 32'(y_s1[31:0] * HASH_C1[63:32]);
			hl_s2   <= 32'(y_s1[63:32] * HASH_C1[31:0]);
			kind_s3 <= kind_s2;
			y_s3    <= mix3;
			kind_s4 <= kind_s3;
			ll_s4   <= y_s3[31:0] * HASH_C2[31:0];
			lh_s4   <= 32'(y_s3[31:0] * HASH_C2[63:32]);
			hl_s4   <= 32'(y_s3[63:32] * HASH_C2[31:0]);
			kind_s5 <= kind_s4;
			h_s5    <= mix5;
			kind_s6 <= kind_s5;
			idx_s6  <= h_s5[63 -: IDX_W] >> (PREC_W'(IDX_W) - prec);
			for (int g = 0; g < 8; g++) begin
				nz_s6[g] <= |m5[63-8*g -: 8];
				lz_s6[g] <= clz8(m5[63-8*g -: 8]);
			end
		end
	end

	// first nonzero byte from the top sets the leading zero count
	always_comb begin
		clz = 7'd64;
		for (int g = 7; g >= 0; g--) begin
			if (nz_s6[g]) clz = 7'(8 * g) + 7'(lz_s6[g]);
		end
	end

	assign push         = valid_s6 && !q_full;
	assign push_op.kind = kind_s6;
	assign push_op.idx  = idx_s6;
	assign push_op.rank = RANK_W'(clz + 7'd1 - 7'(prec));

endmodule

// ===== hdl/hll_queue.sv =====
// small queue of classified items between front and back
module hll_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  hll_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output hll_pkg::op_t head,
	output logic         head_valid
);
	import hll_pkg::*;

	op_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push) count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_op;
	end

endmodule

// ===== hdl/hll_back.sv =====
// back end: rank store, max update, clear and summary sweeps, result register
module hll_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hll_pkg::PREC_W-1:0] prec,
	input  hll_pkg::op_t              head,
	input  logic                      head_valid,
	output logic                      pop,
	output logic                      init_busy,
	output logic                      res_valid,
	input  logic                      res_ready,
	output hll_pkg::result_t          res
);
	import hll_pkg::*;

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_ADD_WR = 6'b000100,
		ST_SWEEP  = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	logic [RANK_W-1:0] mem [DEPTH];

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  last_idx;
	logic              we;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [RANK_W-1:0] wdata;
	logic [RANK_W-1:0] rd_q;
	logic              rd_vld_q, rd_vld_d;
	logic              acc_clr, load_res;
	logic [63:0]       acc_q, term;
	logic [ZCNT_W-1:0] zcnt_q;
	logic              res_valid_q;
	result_t           res_q;

	assign last_idx  = last_index(prec);
	assign init_busy = state_q == ST_INIT;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pop      = 1'b0;
		we       = 1'b0;
		waddr    = cnt_q;
		wdata    = '0;
		raddr    = cnt_q;
		rd_vld_d = 1'b0;
		acc_clr  = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				cnt_d = cnt_q + IDX_W'(1);
				if (cnt_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head.kind) inside
						KIND_ADD: begin
							raddr   = head.idx;
							state_d = ST_ADD_WR;
						end
						KIND_CLEAR, KIND_SUM: begin
							cnt_d   = '0;
							acc_clr = 1'b1;
							state_d = ST_SWEEP;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_ADD_WR: begin
				waddr   = head.idx;
				wdata   = head.rank;
				we      = head.rank > rd_q;
				pop     = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (head.kind == KIND_CLEAR) we = 1'b1;
				else rd_vld_d = 1'b1;
				cnt_d = cnt_q + IDX_W'(1);
				if (cnt_q == last_idx) begin
					cnt_d = '0;
					if (head.kind == KIND_CLEAR) begin
						pop     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					load_res = 1'b1;
					pop      = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign term = (rd_q <= RANK_W'(FRAC_BITS)) ? (64'd1 << (RANK_W'(FRAC_BITS) - rd_q)) : 64'd0;

	always_ff @(posedge clk) begin
		if (acc_clr) begin
			acc_q  <= '0;
			zcnt_q <= '0;
		end else if (rd_vld_q) begin
			acc_q  <= acc_q + term;
			zcnt_q <= zcnt_q + ZCNT_W'(rd_q == '0);
		end
		if (load_res) begin
			res_q.inv_rank_sum <= acc_q;
			res_q.zero_count   <= zcnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			rd_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			rd_vld_q <= rd_vld_d;
			if (load_res) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_add_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_WR) |-> ($past(state_q) == ST_IDLE && head.kind == KIND_ADD))
		else $error("rank write without a preceding add read");

	a_zcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (zcnt_q <= ZCNT_W'(DEPTH)))
		else $error("zero count beyond store depth");

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> (!pop && !res_valid_q))
		else $error("activity during store initialization");

endmodule

// ===== hdl/hyperloglog_sketch.sv =====
// top level of the hyperloglog cardinality sketch
// Usage:
// - item channel (item_valid/item_ready/item) takes add, clear and summarize items;
//   unknown kinds are dropped without effect.
// - res channel (res_valid/res_ready/res) returns one result per summarize item.
// - cfg_we/cfg_wdata write the precision register; write only while idle.
// Flow:
// - every item runs the pipelined hash, then waits in a 4-entry queue.
// - add: store read in ST_IDLE, then max write in ST_ADD_WR; the back end
//   takes the next item only after that write, as the FSM returns to ST_IDLE.
// - clear and summarize sweep the 2^precision entries in use, one store entry
//   per cycle; summarize then passes ST_DRAIN and ST_DONE to the result register.
// Reset:
// - precision returns to 14 and the rank store is zeroed by a sweep of all
//   65536 entries, during which item_ready stays low.
// Stalls:
// - a waiting result is held in the output register while adds and clears go on;
//   a second summarize holds in the back end until the first result is taken,
//   and the queue fills back into item_ready.
module hyperloglog_sketch (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  hll_pkg::item_t             item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output hll_pkg::result_t           res,
	input  logic                       cfg_we,
	input  logic [hll_pkg::PREC_W-1:0] cfg_wdata
);
	import hll_pkg::*;

	logic [PREC_W-1:0] prec_q, prec;
	logic              push, q_full, pop, head_valid, init_busy;
	op_t               push_op, head;

	assign prec = eff_prec(prec_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prec_q <= PREC_RESET;
		else if (cfg_we) prec_q <= cfg_wdata;
	end

	hll_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.hold       (init_busy),
		.prec       (prec),
		.push       (push),
		.push_op    (push_op),
		.q_full     (q_full)
	);

	hll_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	hll_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.prec       (prec),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.init_busy  (init_busy),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule
